// File: rtl/assert_macros.svh
// assertion macros for the rtl files; only gif_lzw_code_packer includes them
// no dependencies; the files that assert expect clk_i and rst_ni in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GLZW_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
`define GLZW_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (expr)) \
    else $error(msg);
`else
`define GLZW_ASSERT(label, expr, msg)
`define GLZW_ASSERT_NEXT(label, cond, expr, msg)
`endif
`endif

// File: rtl/glzw_pkg.sv
// shared types and constants of the gif lzw code packer
// no dependencies
package glzw_pkg;

  localparam int MAX_WIDTH        = 12;
  localparam int CODE_LIMIT_DEF   = 4096;
  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int EPOCH_W          = 8;
  localparam int PACK_BYTES       = 6;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_END   = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [PACK_BYTES*8-1:0] bytes;
    logic [2:0]              count;
  } pack_t;

endpackage

// File: rtl/glzw_if.sv
// handshake channels of the gif lzw code packer: command input and byte output
// no dependencies
interface glzw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] pixel_index;
  modport source (output valid, cmd, pixel_index, input ready);
  modport sink (input valid, cmd, pixel_index, output ready);
endinterface

interface glzw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink (input valid, out_byte, last_of_run, output ready);
endinterface

// File: rtl/gif_lzw_code_packer.sv
// gif lzw code packer: pixels in, lsb-first packed lzw code bytes out
// an accepted item's child table read is registered; the item resolves when
//   the word returns, and its bytes go to the serializer, one byte a cycle
//   while out ready is high; no new item is taken while one is in resolve,
//   and an item stays in resolve until its bytes fit in the serializer
// reset: clearing pass over all CODE_LIMIT*SYMBOL_COUNT words of the child table
//   (1048576 with defaults), repeated each time the 8-bit epoch wraps
`include "assert_macros.svh"

module gif_lzw_code_packer
  import glzw_pkg::*;
#(
  parameter int CODE_LIMIT   = CODE_LIMIT_DEF,
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i,
  glzw_in_if.sink    in_i,
  glzw_out_if.source out_o
);
  localparam int DEPTH = CODE_LIMIT * SYMBOL_COUNT;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = EPOCH_W + MAX_WIDTH;

  // mask a code down to its width
  function automatic logic [MAX_WIDTH-1:0] fit_code(input logic [12:0] code,
                                                   input logic [3:0] w);
    logic [12:0] m;
    m = (13'd1 << w) - 13'd1;
    return MAX_WIDTH'(code & m);
  endfunction

  // architectural state
  logic [2:0]         pal_q;
  logic [12:0]        next_code_q, next_code_d;
  logic [3:0]         width_q, width_d;
  logic [11:0]        prefix_q, prefix_d;
  logic               have_q, have_d;
  logic [7:0]         part_byte_q, part_byte_d;
  logic [2:0]         part_bits_q, part_bits_d;
  logic [EPOCH_W-1:0] epoch_q;
  logic               clearing_q;
  logic [AW-1:0]      clr_addr_q;

  // resolve stage: the transaction whose table word is being read
  logic               r_valid_q;
  logic [1:0]         r_cmd_q;
  logic [7:0]         r_sym_q;
  logic               r_inside_q;
  logic [AW-1:0]      r_slot_q;

  logic        accept;
  logic [8:0]  clr_code;
  logic [7:0]  sym_mask, sym_raw, sym;
  logic        in_tbl;
  logic [AW-1:0] slot;

  assign accept     = in_i.valid && in_i.ready;
  assign in_i.ready = !r_valid_q && !clearing_q;

  // palette-dependent symbols
  assign clr_code = 9'd2 << pal_q;
  assign sym_mask = 8'(clr_code - 9'd1);
  assign sym_raw  = in_i.pixel_index & sym_mask;
  assign sym      = (9'(sym_raw) > 9'(SYMBOL_COUNT - 1)) ? 8'(SYMBOL_COUNT - 1) : sym_raw;
  assign in_tbl   = (32'(prefix_q) < 32'(CODE_LIMIT));
  assign slot     = AW'(32'(prefix_q) * 32'(SYMBOL_COUNT) + 32'(sym));

  // child table: {epoch, code}; a word only counts when its epoch is current
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata, ram_rdata;
  logic          tbl_write;

  glzw_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_tbl (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (slot),
    .rdata_o (ram_rdata)
  );

  // resolve logic
  logic [11:0] child;
  logic        hit, bump, pad, r_done, ser_ok;
  logic [11:0] c0, c1, c2;
  logic [3:0]  w0, w1, w2, w_grow;
  logic [12:0] nc_inc;
  logic [5:0]  sh1, sh2, nbits;
  logic [2:0]  nbytes;
  logic [47:0] acc, rest;
  pack_t       pack;

  assign child = ram_rdata[MAX_WIDTH-1:0];
  assign hit   = r_inside_q && (ram_rdata[WW-1:MAX_WIDTH] == epoch_q) && (child != 12'd0);

  always_comb begin
    next_code_d = next_code_q;
    width_d     = width_q;
    prefix_d    = prefix_q;
    have_d      = have_q;
    c0 = '0; c1 = '0; c2 = '0;
    w0 = '0; w1 = '0; w2 = '0;
    bump      = 1'b0;
    pad       = 1'b0;
    tbl_write = 1'b0;
    w_grow    = width_q;
    nc_inc    = next_code_q + 13'd1;
    case (r_cmd_q)
      CMD_START: begin
        width_d     = 4'(pal_q) + 4'd2;
        next_code_d = 13'(clr_code) + 13'd2;
        have_d      = 1'b0;
        prefix_d    = '0;
        bump        = 1'b1;
        c0          = fit_code(13'(clr_code), width_d);
        w0          = width_d;
      end
      CMD_PIXEL: begin
        if (width_q != 4'd0) begin
          if (!have_q) begin
            prefix_d = 12'(r_sym_q);
            have_d   = 1'b1;
          end else if (hit) begin
            prefix_d = child;
          end else begin
            // miss: send the prefix, grow, add the entry
            c0 = fit_code(13'(prefix_q), width_q);
            w0 = width_q;
            if ((next_code_q == (13'd1 << width_q)) && (width_q < 4'(MAX_WIDTH))) begin
              w_grow = width_q + 4'd1;
            end
            tbl_write = r_inside_q;
            width_d     = w_grow;
            next_code_d = nc_inc;
            if (32'(nc_inc) >= 32'(CODE_LIMIT)) begin
              // dictionary full: clear code and restart
              c1          = fit_code(13'(clr_code), w_grow);
              w1          = w_grow;
              width_d     = 4'(pal_q) + 4'd2;
              next_code_d = 13'(clr_code) + 13'd2;
              bump        = 1'b1;
            end
            prefix_d = 12'(r_sym_q);
          end
        end
      end
      CMD_END: begin
        if (width_q != 4'd0) begin
          if (have_q) begin
            c0 = fit_code(13'(prefix_q), width_q);
            w0 = width_q;
          end
          c1 = fit_code(13'(clr_code), width_q);
          w1 = width_q;
          c2 = fit_code(13'(clr_code) + 13'd1, width_q);
          w2 = width_q;
          pad         = 1'b1;
          bump        = 1'b1;
          have_d      = 1'b0;
          prefix_d    = '0;
          width_d     = '0;
          next_code_d = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // bit packing after the pending partial byte
  always_comb begin
    sh1    = 6'(part_bits_q) + 6'(w0);
    sh2    = sh1 + 6'(w1);
    nbits  = sh2 + 6'(w2);
    acc    = 48'(part_byte_q) | (48'(c0) << part_bits_q) | (48'(c1) << sh1)
           | (48'(c2) << sh2);
    nbytes = nbits[5:3];
    rest   = acc >> {nbytes, 3'b000};
    pack.bytes = acc;
    pack.count = nbytes + 3'(pad && (nbits[2:0] != 3'd0));
    if (pad) begin
      part_byte_d = '0;
      part_bits_d = '0;
    end else begin
      part_byte_d = rest[7:0];
      part_bits_d = nbits[2:0];
    end
  end

  // the item leaves resolve once its bytes fit in the serializer
  assign r_done = r_valid_q && ((pack.count == 3'd0) || ser_ok);

  glzw_ser u_ser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (r_done && (pack.count != 3'd0)),
    .pack_i    (pack),
    .load_ok_o (ser_ok),
    .out_o     (out_o)
  );

  // table write: clearing pass, or the new entry at commit
  assign ram_we    = clearing_q || (r_done && tbl_write);
  assign ram_waddr = clearing_q ? clr_addr_q : r_slot_q;
  assign ram_wdata = clearing_q ? '0 : {epoch_q, 12'(next_code_q)};

  logic [EPOCH_W-1:0] epoch_inc;
  assign epoch_inc = epoch_q + EPOCH_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_q       <= 3'd7;
      next_code_q <= '0;
      width_q     <= '0;
      prefix_q    <= '0;
      have_q      <= 1'b0;
      part_byte_q <= '0;
      part_bits_q <= '0;
      epoch_q     <= '0;
      clearing_q  <= 1'b1;
      clr_addr_q  <= '0;
      r_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pal_q <= cfg_wdata_i;
      end
      if (accept) begin
        r_valid_q <= 1'b1;
      end else if (r_done) begin
        r_valid_q <= 1'b0;
      end
      if (r_done) begin
        next_code_q <= next_code_d;
        width_q     <= width_d;
        prefix_q    <= prefix_d;
        have_q      <= have_d;
        part_byte_q <= part_byte_d;
        part_bits_q <= part_bits_d;
        if (bump) begin
          epoch_q <= epoch_inc;
          if (epoch_inc == '0) begin
            // epoch wrapped: stale words could match again
            clearing_q <= 1'b1;
            clr_addr_q <= '0;
          end
        end
      end
      if (clearing_q) begin
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          clearing_q <= 1'b0;
          epoch_q    <= EPOCH_W'(1);
        end else begin
          clr_addr_q <= clr_addr_q + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      r_cmd_q    <= in_i.cmd;
      r_sym_q    <= sym;
      r_inside_q <= in_tbl;
      r_slot_q   <= slot;
    end
  end

  `GLZW_ASSERT_NEXT(a_accept_resolves, accept, r_valid_q, "accepted item not in resolve")
  `GLZW_ASSERT(a_no_resolve_in_clear, !(clearing_q && r_valid_q), "resolve during clearing")
  `GLZW_ASSERT(a_width_range, (width_q == 4'd0) || (width_q >= 4'd2), "code width too small")
  `GLZW_ASSERT(a_width_max, width_q <= 4'(MAX_WIDTH), "code width too large")
  `GLZW_ASSERT(a_next_code_limit, 32'(next_code_q) < 32'(CODE_LIMIT), "next code reached limit")
endmodule

// File: rtl/glzw_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module glzw_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// File: rtl/glzw_ser.sv
// byte serializer: takes a packet of up to six bytes, sends one byte a cycle while out ready is high
// depends on glzw_pkg and glzw_out_if
module glzw_ser
  import glzw_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   load_i,
  input  pack_t  pack_i,
  output logic   load_ok_o,
  glzw_out_if.source out_o
);
  logic [PACK_BYTES*8-1:0] buf_q, buf_d;
  logic [2:0]              cnt_q, cnt_d;
  logic                    fire;

  assign fire      = out_o.valid && out_o.ready;
  assign load_ok_o = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_o.ready);

  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (load_i) begin
      buf_d = pack_i.bytes;
      cnt_d = pack_i.count;
    end else if (fire) begin
      buf_d = buf_q >> 8;
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  assign out_o.valid       = (cnt_q != 3'd0);
  assign out_o.out_byte    = buf_q[7:0];
  assign out_o.last_of_run = (cnt_q == 3'd1);
endmodule
